### rtl/core/vmsp_pkg.sv
// types, codes and defaults shared by the voxel model stream parser
package vmsp_pkg;

    localparam int MAX_VOXELS_DEF = 4096;
    localparam int MAX_SIDE_DEF   = 256;

    localparam logic [31:0] MAGIC_WORD = 32'h6C78764B;
    localparam logic [31:0] COLOR_MASK = 32'h00FFFFFF;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_VOXEL  = 2'd1;
    localparam logic [1:0] KIND_COLUMN = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    localparam logic [1:0] ERR_BAD_MAGIC  = 2'd0;
    localparam logic [1:0] ERR_TOO_MANY   = 2'd1;
    localparam logic [1:0] ERR_SIZE_LARGE = 2'd2;
    localparam logic [1:0] ERR_COL_OVERRUN = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       file_start;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [12:0] voxel_index;
        logic [23:0] color;
        logic [7:0]  lighting;
        logic [7:0]  visible_faces;
        logic [15:0] z_coord;
        logic [7:0]  column_x;
        logic [7:0]  column_y;
        logic [15:0] column_count;
        logic [1:0]  error_code;
    } out_item_t;

endpackage

### rtl/core/vmsp_parse.sv
// parse state and per-byte decode of the voxel model stream
module vmsp_parse #(
    parameter int MAX_VOXELS = vmsp_pkg::MAX_VOXELS_DEF,
    parameter int MAX_SIDE   = vmsp_pkg::MAX_SIDE_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  vmsp_pkg::in_item_t  item,
    output logic                hit,
    output vmsp_pkg::out_item_t res
);
    import vmsp_pkg::*;

    localparam int VOX_W  = $clog2(MAX_VOXELS + 1);
    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int POS_W  = (SIDE_W + 2 > 5) ? SIDE_W + 2 : 5;
    localparam int SUM_W  = ((VOX_W > 16) ? VOX_W : 16) + 1;
    localparam logic [31:0] SIDE_LIM = 32'(MAX_SIDE);
    localparam logic [31:0] VOX_LIM  = 32'(MAX_VOXELS);

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_HEADER  = 3'd1;
    localparam logic [2:0] PH_RECORDS = 3'd2;
    localparam logic [2:0] PH_OFFSETS = 3'd3;
    localparam logic [2:0] PH_COLUMNS = 3'd4;
    localparam logic [2:0] PH_DONE    = 3'd5;
    localparam logic [2:0] PH_FAULT   = 3'd6;

    logic [2:0]        phase_reg, phase_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [31:0]       word_reg, word_next;
    logic [SIDE_W-1:0] size_x_reg, size_x_next;
    logic [SIDE_W-1:0] size_y_reg, size_y_next;
    logic [SIDE_W-1:0] size_z_reg, size_z_next;
    logic [VOX_W-1:0]  declared_reg, declared_next;
    logic [VOX_W-1:0]  records_reg, records_next;
    logic [VOX_W-1:0]  assigned_reg, assigned_next;
    logic [SIDE_W-1:0] col_x_reg, col_x_next;
    logic [SIDE_W-1:0] col_y_reg, col_y_next;
    logic [23:0]       color_reg, color_next;

    logic [2:0]        ph;
    logic [POS_W-1:0]  pos;
    logic [VOX_W-1:0]  records_cur;
    logic [VOX_W-1:0]  assigned_cur;
    logic [31:0]       word_shift;
    logic [15:0]       count;
    logic [SUM_W-1:0]  sum;
    logic [VOX_W:0]    records_inc;
    logic [SIDE_W:0]   col_y_inc;
    logic [SIDE_W:0]   col_x_inc;
    logic              go_off;
    logic              go_col;

    always_comb
    begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        word_next     = word_reg;
        size_x_next   = size_x_reg;
        size_y_next   = size_y_reg;
        size_z_next   = size_z_reg;
        declared_next = declared_reg;
        records_next  = records_reg;
        assigned_next = assigned_reg;
        col_x_next    = col_x_reg;
        col_y_next    = col_y_reg;
        color_next    = color_reg;
        hit           = 1'b0;
        res           = '0;
        go_off        = 1'b0;
        go_col        = 1'b0;

        ph           = item.file_start ? PH_HEADER : phase_reg;
        pos          = item.file_start ? '0 : pos_reg;
        records_cur  = item.file_start ? '0 : records_reg;
        assigned_cur = item.file_start ? '0 : assigned_reg;
        word_shift   = {item.data_byte, word_reg[31:8]};
        count        = word_shift[31:16];
        sum          = SUM_W'(assigned_cur) + SUM_W'(count);
        records_inc  = (VOX_W + 1)'(records_cur) + 1'b1;
        col_y_inc    = (SIDE_W + 1)'(col_y_reg) + 1'b1;
        col_x_inc    = (SIDE_W + 1)'(col_x_reg) + 1'b1;

        if (step)
        begin
            if (item.file_start)
            begin
                phase_next    = PH_HEADER;
                pos_next      = '0;
                records_next  = '0;
                assigned_next = '0;
            end
            if (ph != PH_IDLE && ph != PH_DONE && ph != PH_FAULT)
            begin
                word_next = word_shift;
                pos_next  = pos + 1'b1;
            end
            case (ph)
                PH_HEADER:
                begin
                    if (pos == POS_W'(3) && word_shift != MAGIC_WORD)
                    begin
                        hit = 1'b1;
                        res.kind = KIND_ERROR;
                        res.error_code = ERR_BAD_MAGIC;
                        phase_next = PH_FAULT;
                    end
                    else if ((pos == POS_W'(7) || pos == POS_W'(11) || pos == POS_W'(15))
                             && word_shift > SIDE_LIM)
                    begin
                        hit = 1'b1;
                        res.kind = KIND_ERROR;
                        res.error_code = ERR_SIZE_LARGE;
                        phase_next = PH_FAULT;
                    end
                    else if (pos == POS_W'(7))
                    begin
                        size_x_next = SIDE_W'(word_shift);
                    end
                    else if (pos == POS_W'(11))
                    begin
                        size_y_next = SIDE_W'(word_shift);
                    end
                    else if (pos == POS_W'(15))
                    begin
                        size_z_next = SIDE_W'(word_shift);
                    end
                    else if (pos == POS_W'(31))
                    begin
                        hit = 1'b1;
                        if (word_shift > VOX_LIM)
                        begin
                            res.kind = KIND_ERROR;
                            res.error_code = ERR_TOO_MANY;
                            phase_next = PH_FAULT;
                        end
                        else
                        begin
                            res.kind = KIND_HEADER;
                            res.voxel_index = 13'(word_shift);
                            declared_next = VOX_W'(word_shift);
                            records_next = '0;
                            pos_next = '0;
                            if (word_shift == 32'd0)
                                go_off = 1'b1;
                            else
                                phase_next = PH_RECORDS;
                        end
                    end
                end
                PH_RECORDS:
                begin
                    if (pos == POS_W'(3))
                        color_next = 24'(word_shift & COLOR_MASK);
                    if (pos >= POS_W'(7))
                    begin
                        hit = 1'b1;
                        res.kind = KIND_VOXEL;
                        res.voxel_index = 13'(records_cur);
                        res.color = color_reg;
                        res.lighting = word_shift[31:24];
                        res.visible_faces = word_shift[23:16];
                        res.z_coord = 16'(size_z_reg) - 16'd1 - word_shift[15:0];
                        records_next = VOX_W'(records_inc);
                        pos_next = '0;
                        if (records_inc >= (VOX_W + 1)'(declared_reg))
                            go_off = 1'b1;
                    end
                end
                PH_OFFSETS:
                begin
                    // offset table is 4 bytes per x slice
                    if ((POS_W + 1)'(pos) + 1'b1 >= (POS_W + 1)'({size_x_reg, 2'b00}))
                        go_col = 1'b1;
                end
                PH_COLUMNS:
                begin
                    if (pos != '0)
                    begin
                        pos_next = '0;
                        hit = 1'b1;
                        if (sum > SUM_W'(declared_reg))
                        begin
                            res.kind = KIND_ERROR;
                            res.error_code = ERR_COL_OVERRUN;
                            phase_next = PH_FAULT;
                        end
                        else
                        begin
                            res.kind = KIND_COLUMN;
                            res.voxel_index = 13'(assigned_cur);
                            res.column_x = 8'(col_x_reg);
                            res.column_y = 8'(col_y_reg);
                            res.column_count = count;
                            assigned_next = VOX_W'(sum);
                            // y runs inner, x outer
                            if (col_y_inc >= (SIDE_W + 1)'(size_y_reg))
                            begin
                                col_y_next = '0;
                                col_x_next = SIDE_W'(col_x_inc);
                                if (col_x_inc >= (SIDE_W + 1)'(size_x_reg))
                                    phase_next = PH_DONE;
                            end
                            else
                            begin
                                col_y_next = SIDE_W'(col_y_inc);
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase

            if (go_off)
            begin
                pos_next = '0;
                if (size_x_reg == '0)
                    go_col = 1'b1;
                else
                    phase_next = PH_OFFSETS;
            end
            if (go_col)
            begin
                pos_next   = '0;
                col_x_next = '0;
                col_y_next = '0;
                phase_next = (size_x_reg == '0 || size_y_reg == '0) ? PH_DONE : PH_COLUMNS;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            pos_reg      <= '0;
            word_reg     <= '0;
            size_x_reg   <= '0;
            size_y_reg   <= '0;
            size_z_reg   <= '0;
            declared_reg <= '0;
            records_reg  <= '0;
            assigned_reg <= '0;
            col_x_reg    <= '0;
            col_y_reg    <= '0;
            color_reg    <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            word_reg     <= word_next;
            size_x_reg   <= size_x_next;
            size_y_reg   <= size_y_next;
            size_z_reg   <= size_z_next;
            declared_reg <= declared_next;
            records_reg  <= records_next;
            assigned_reg <= assigned_next;
            col_x_reg    <= col_x_next;
            col_y_reg    <= col_y_next;
            color_reg    <= color_next;
        end
    end

endmodule

### rtl/core/voxel_model_stream_parser.sv
// top level of the voxel model stream parser: input register, decode, result register
//
// channel  direction  handshake             payload
// in       input      in_valid / in_ready   in_data   (data_byte, file_start)
// out      output     out_valid / out_ready out_data  (kind .. error_code)
//
// one byte item is taken per cycle while out_ready does not stall the result register; the accepting
// edge loads the input register, and the byte is decoded into the result register once that
// register can advance; out_valid then rises if the byte gave a result.
// a byte gives at most one result; most bytes give none and leave no output bubble.
// rst_n clears the handshake state and leaves the parser idle until a file_start item.
// out_ready low stalls the result register, which in turn holds the input register.
module voxel_model_stream_parser #(
    parameter int MAX_VOXELS = vmsp_pkg::MAX_VOXELS_DEF,
    parameter int MAX_SIDE   = vmsp_pkg::MAX_SIDE_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  vmsp_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output vmsp_pkg::out_item_t out_data
);
    import vmsp_pkg::*;

    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    logic      advance;
    logic      step;
    logic      hit;
    out_item_t res;

    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = !in_valid_reg || advance;
    assign step      = in_valid_reg && advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    vmsp_parse #(
        .MAX_VOXELS (MAX_VOXELS),
        .MAX_SIDE   (MAX_SIDE)
    ) u_parse (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (in_item_reg),
        .hit   (hit),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= step && hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_item_reg <= in_data;
        if (step && hit)
            out_item_reg <= res;
    end

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
// self-checking testbench for the voxel model stream parser: byte streams in, parse results checked
module tb_top;
    import vmsp_pkg::*;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 16;
    localparam int RANDOM_BYTES = 500;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_RECORDS,
        PH_OFFSETS,
        PH_COLUMNS,
        PH_DONE,
        PH_FAULT
    } parse_phase_t;

    class voxel_parse_scoreboard;
        parse_phase_t phase;
        logic [31:0]  byte_pos;
        logic [31:0]  shift_word;
        logic [31:0]  size_x;
        logic [31:0]  size_y;
        logic [31:0]  size_z;
        logic [31:0]  declared;
        logic [31:0]  records;
        logic [31:0]  assigned;
        logic [31:0]  col_x;
        logic [31:0]  col_y;
        logic [23:0]  colour_hold;
        out_item_t    pending_results[$];
        int           mismatches;
        int           headers;
        int           voxels;
        int           columns;
        int           faults;

        function new();
            clear_state();
            mismatches = 0;
            headers    = 0;
            voxels     = 0;
            columns    = 0;
            faults     = 0;
        endfunction

        function void clear_state();
            phase       = PH_IDLE;
            byte_pos    = '0;
            shift_word  = '0;
            size_x      = '0;
            size_y      = '0;
            size_z      = '0;
            declared    = '0;
            records     = '0;
            assigned    = '0;
            col_x       = '0;
            col_y       = '0;
            colour_hold = '0;
        endfunction

        function void enter_columns();
            byte_pos = '0;
            col_x    = '0;
            col_y    = '0;
            if (size_x == 0 || size_y == 0)
                phase = PH_DONE;
            else
                phase = PH_COLUMNS;
        endfunction

        function void enter_offsets();
            byte_pos = '0;
            if (size_x == 0)
                enter_columns();
            else
                phase = PH_OFFSETS;
        endfunction

        function void push_error(logic [1:0] code);
            out_item_t r;
            r            = '0;
            r.kind       = KIND_ERROR;
            r.error_code = code;
            pending_results.push_back(r);
            phase = PH_FAULT;
        endfunction

        // advance the parse by one accepted byte and queue the result it causes
        function void note_byte(in_item_t it);
            out_item_t   r;
            logic [31:0] p;
            logic [31:0] cnt;
            logic [31:0] zf;
            r = '0;
            if (it.file_start)
            begin
                clear_state();
                phase = PH_HEADER;
            end
            if (phase == PH_IDLE || phase == PH_DONE || phase == PH_FAULT)
                return;
            shift_word = {it.data_byte, shift_word[31:8]};
            p          = byte_pos;
            byte_pos   = p + 1;
            case (phase)
                PH_HEADER:
                begin
                    if (p == 3 && shift_word != MAGIC_WORD)
                        push_error(ERR_BAD_MAGIC);
                    else if ((p == 7 || p == 11 || p == 15) && shift_word > MAX_SIDE_DEF)
                        push_error(ERR_SIZE_LARGE);
                    else if (p == 7)
                        size_x = shift_word;
                    else if (p == 11)
                        size_y = shift_word;
                    else if (p == 15)
                        size_z = shift_word;
                    else if (p == 31)
                    begin
                        if (shift_word > MAX_VOXELS_DEF)
                            push_error(ERR_TOO_MANY);
                        else
                        begin
                            declared      = shift_word;
                            r.kind        = KIND_HEADER;
                            r.voxel_index = declared[12:0];
                            pending_results.push_back(r);
                            records  = '0;
                            byte_pos = '0;
                            if (declared == 0)
                                enter_offsets();
                            else
                                phase = PH_RECORDS;
                        end
                    end
                end
                PH_RECORDS:
                begin
                    if (p == 3)
                        colour_hold = shift_word[23:0];
                    if (p >= 7)
                    begin
                        // z is flipped against the model height, wrapping at 16 bits
                        zf              = size_z + 32'hFFFF - {16'h0, shift_word[15:0]};
                        r.kind          = KIND_VOXEL;
                        r.voxel_index   = records[12:0];
                        r.color         = colour_hold;
                        r.lighting      = shift_word[31:24];
                        r.visible_faces = shift_word[23:16];
                        r.z_coord       = zf[15:0];
                        pending_results.push_back(r);
                        records  = records + 1;
                        byte_pos = '0;
                        if (records >= declared)
                            enter_offsets();
                    end
                end
                PH_OFFSETS:
                begin
                    if (byte_pos >= 4 * size_x)
                        enter_columns();
                end
                PH_COLUMNS:
                begin
                    if (p != 0)
                    begin
                        cnt      = {16'h0, shift_word[31:16]};
                        byte_pos = '0;
                        if (assigned + cnt > declared)
                            push_error(ERR_COL_OVERRUN);
                        else
                        begin
                            r.kind         = KIND_COLUMN;
                            r.voxel_index  = assigned[12:0];
                            r.column_x     = col_x[7:0];
                            r.column_y     = col_y[7:0];
                            r.column_count = cnt[15:0];
                            pending_results.push_back(r);
                            assigned = assigned + cnt;
                            col_y    = col_y + 1;
                            if (col_y >= size_y)
                            begin
                                col_y = '0;
                                col_x = col_x + 1;
                                if (col_x >= size_x)
                                    phase = PH_DONE;
                            end
                        end
                    end
                end
                default:
                    ;
            endcase
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (pending_results.size() == 0)
            begin
                $error("kind: expected no result, got %0d", got.kind);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("kind", want.kind, got.kind);
            compare_field("voxel_index", want.voxel_index, got.voxel_index);
            compare_field("color", want.color, got.color);
            compare_field("lighting", want.lighting, got.lighting);
            compare_field("visible_faces", want.visible_faces, got.visible_faces);
            compare_field("z_coord", want.z_coord, got.z_coord);
            compare_field("column_x", want.column_x, got.column_x);
            compare_field("column_y", want.column_y, got.column_y);
            compare_field("column_count", want.column_count, got.column_count);
            compare_field("error_code", want.error_code, got.error_code);
            case (want.kind)
                KIND_HEADER: headers++;
                KIND_VOXEL:  voxels++;
                KIND_COLUMN: columns++;
                default:     faults++;
            endcase
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    voxel_parse_scoreboard parser = new();
    in_item_t              file_q[$];
    bit                    calm;
    int                    bytes_sent;
    int                    cycles;

    voxel_model_stream_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still due", cycles,
                     parser.pending_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    function void put_byte(logic [7:0] b, bit st);
        in_item_t it;
        it.data_byte  = b;
        it.file_start = st;
        file_q.push_back(it);
    endfunction

    function void put_word(logic [31:0] w, bit st);
        put_byte(w[7:0], st);
        put_byte(w[15:8], 1'b0);
        put_byte(w[23:16], 1'b0);
        put_byte(w[31:24], 1'b0);
    endfunction

    function void build_noise(int count);
        for (int k = 0; k < count; k++)
            put_byte(8'($urandom), 1'b0);
    endfunction

    // header always; records, offsets and columns only when the header is legal
    function void build_file(logic [31:0] magic, logic [31:0] sx, logic [31:0] sy,
                             logic [31:0] sz, logic [31:0] n, bit overrun);
        logic [31:0] remaining;
        logic [31:0] cnt;
        logic [15:0] zpos;
        int          total;
        int          bad;
        put_word(magic, 1'b1);
        put_word(sx, 1'b0);
        put_word(sy, 1'b0);
        put_word(sz, 1'b0);
        for (int k = 0; k < 3; k++)
            put_word($urandom, 1'b0);
        put_word(n, 1'b0);
        if (magic != MAGIC_WORD || sx > MAX_SIDE_DEF || sy > MAX_SIDE_DEF ||
            sz > MAX_SIDE_DEF || n > MAX_VOXELS_DEF)
            return;
        for (int k = 0; k < n; k++)
        begin
            put_word($urandom, 1'b0);
            zpos = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 300));
            put_byte(zpos[7:0], 1'b0);
            put_byte(zpos[15:8], 1'b0);
            put_byte(8'($urandom), 1'b0);
            put_byte(8'($urandom), 1'b0);
        end
        build_noise(4 * sx);
        total     = sx * sy;
        bad       = (overrun && total > 0) ? $urandom_range(0, total - 1) : total;
        remaining = n;
        for (int k = 0; k < total; k++)
        begin
            if (k == bad)
                cnt = remaining + 1 + $urandom_range(0, 65534 - remaining);
            else if (k == total - 1 && $urandom_range(0, 3) != 0)
                cnt = remaining;
            else if ($urandom_range(0, 3) == 0)
                cnt = 0;
            else
                cnt = $urandom_range(0, remaining);
            if (k != bad)
                remaining = remaining - cnt;
            put_byte(cnt[7:0], 1'b0);
            put_byte(cnt[15:8], 1'b0);
        end
    endfunction

    function void truncate_file(int keep);
        while (file_q.size() > keep)
            void'(file_q.pop_back());
    endfunction

    task automatic send_byte(in_item_t it);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        parser.note_byte(it);
        bytes_sent++;
    endtask

    task automatic play_bytes();
        calm = ($urandom_range(0, 4) == 0);
        while (file_q.size() != 0)
            send_byte(file_q.pop_front());
    endtask

    task automatic run_directed();
        // bytes before any start are ignored
        build_noise(4);
        play_bytes();
        build_file(MAGIC_WORD ^ 32'h0100_0000, 1, 1, 1, 1, 1'b0);
        build_noise(3);
        play_bytes();
        build_file(MAGIC_WORD, MAX_SIDE_DEF + 1, 1, 1, 0, 1'b0);
        play_bytes();
        build_file(MAGIC_WORD, 4, 32'hFFFF_FFFF, 1, 0, 1'b0);
        play_bytes();
        build_file(MAGIC_WORD, 4, 4, 32'h8000_0100, 0, 1'b0);
        play_bytes();
        build_file(MAGIC_WORD, 2, 2, 2, MAX_VOXELS_DEF + 1, 1'b0);
        play_bytes();
        build_file(MAGIC_WORD, 2, 2, 2, 32'hFFFF_FFFF, 1'b0);
        play_bytes();
        // trailing bytes after the last column
        build_file(MAGIC_WORD, 2, 3, 5, 6, 1'b0);
        build_noise(5);
        play_bytes();
        build_file(MAGIC_WORD, 3, 2, 0, 0, 1'b0);
        play_bytes();
        build_file(MAGIC_WORD, 0, 4, 9, 3, 1'b0);
        play_bytes();
        build_file(MAGIC_WORD, 2, 0, 9, 3, 1'b0);
        play_bytes();
        build_file(MAGIC_WORD, 3, 3, 200, 10, 1'b1);
        play_bytes();
        // sizes at the limit pass the header; file cut short inside the offsets
        build_file(MAGIC_WORD, MAX_SIDE_DEF, 1, MAX_SIDE_DEF, 0, 1'b0);
        truncate_file(40);
        play_bytes();
        build_file(MAGIC_WORD, 1, 12, 0, 8, 1'b0);
        play_bytes();
        // largest voxel count passes the header; only the first records follow
        build_file(MAGIC_WORD, 1, 1, MAX_SIDE_DEF, MAX_VOXELS_DEF, 1'b0);
        truncate_file(56);
        play_bytes();
        // restart in the middle of a record
        build_file(MAGIC_WORD, 2, 2, 7, 4, 1'b0);
        truncate_file(45);
        build_file(MAGIC_WORD, 2, 2, 7, 4, 1'b0);
        play_bytes();
    endtask

    task automatic run_random();
        int          first;
        int          pick;
        int          idx;
        logic [31:0] magic;
        logic [31:0] sx;
        logic [31:0] sy;
        logic [31:0] sz;
        logic [31:0] n;
        in_item_t    it;
        first = bytes_sent;
        while (bytes_sent - first < RANDOM_BYTES)
        begin
            pick  = $urandom_range(0, 99);
            magic = MAGIC_WORD;
            sx    = $urandom_range(0, 5);
            sy    = $urandom_range(0, 5);
            sz    = $urandom_range(0, MAX_SIDE_DEF);
            n     = $urandom_range(0, 12);
            if (pick < 65)
                build_file(magic, sx, sy, sz, n, $urandom_range(0, 6) == 0);
            else if (pick < 77)
            begin
                case ($urandom_range(0, 4))
                    0: magic = MAGIC_WORD ^ (32'h1 << $urandom_range(0, 31));
                    1: sx = $urandom_range(0, 1) ? $urandom_range(257, 600) : $urandom | 32'h1000;
                    2: sy = $urandom_range(0, 1) ? $urandom_range(257, 600) : $urandom | 32'h1000;
                    3: sz = $urandom_range(0, 1) ? $urandom_range(257, 600) : $urandom | 32'h1000;
                    default: n = $urandom_range(0, 1) ? $urandom_range(4097, 9000) : $urandom | 32'h8000_0000;
                endcase
                build_file(magic, sx, sy, sz, n, 1'b0);
                build_noise($urandom_range(0, 6));
            end
            else if (pick < 89)
            begin
                build_file(magic, sx, sy, sz, n, 1'b0);
                truncate_file($urandom_range(1, file_q.size() - 1));
            end
            else
            begin
                // one damaged byte somewhere in an otherwise legal file
                build_file(magic, sx, sy, sz, n, 1'b0);
                idx            = $urandom_range(0, file_q.size() - 1);
                it             = file_q[idx];
                it.data_byte   = it.data_byte ^ 8'($urandom_range(1, 255));
                file_q[idx]    = it;
            end
            if ($urandom_range(0, 3) == 0)
                build_noise($urandom_range(1, 3));
            play_bytes();
        end
    endtask

    // result side: random stall before taking each item
    initial
    begin
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 4);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            parser.check_result(out_data);
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        calm       = 1'b0;
        bytes_sent = 0;
        cycles     = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random();
        in_valid <= 1'b0;
        while (parser.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("streamed %0d bytes: %0d headers, %0d voxel records, %0d columns, %0d errors",
                 bytes_sent, parser.headers, parser.voxels, parser.columns, parser.faults);
        $display("field mismatches or unexpected results: %0d", parser.mismatches);
        if (parser.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
